// ===== src/clni_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cubic lattice neighbor ID block: widths, register and
// direction codes, payload structs and the per-axis step function. No dependencies.
package clni_pkg;

   localparam int SIDE_BITS         = 10;
   localparam int SIZE_W            = SIDE_BITS + 1;
   localparam int ID_W              = 3 * SIDE_BITS;
   localparam int DIR_W             = 3;
   localparam int CSR_IDX_W         = 3;
   localparam int CLNI_QUEUE_DEPTH  = 2;

   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(1) << SIDE_BITS;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_Z = 3'd5;

   // Offset codes, in emission order.
   localparam logic [DIR_W-1:0] DIR_MINUS_X = 3'd0;
   localparam logic [DIR_W-1:0] DIR_MINUS_Y = 3'd1;
   localparam logic [DIR_W-1:0] DIR_MINUS_Z = 3'd2;
   localparam logic [DIR_W-1:0] DIR_PLUS_Z  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_PLUS_Y  = 3'd4;
   localparam logic [DIR_W-1:0] DIR_PLUS_X  = 3'd5;

   typedef struct packed {
      logic [SIDE_BITS-1:0] site_x;
      logic [SIDE_BITS-1:0] site_y;
      logic [SIDE_BITS-1:0] site_z;
   } req_type;

   typedef struct packed {
      logic                 present;
      logic [ID_W-1:0]      neighbor_id;
      logic [SIDE_BITS-1:0] neighbor_x;
      logic [SIDE_BITS-1:0] neighbor_y;
      logic [SIDE_BITS-1:0] neighbor_z;
      logic [DIR_W-1:0]     direction;
      logic                 last;
   } rsp_type;

   // Clamped lattice configuration as seen by the datapath.
   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
      logic              periodic_x;
      logic              periodic_y;
      logic              periodic_z;
   } cfg_type;

   // Classified site waiting in the queue.
   typedef struct packed {
      logic [SIDE_BITS-1:0] site_x;
      logic [SIDE_BITS-1:0] site_y;
      logic [SIDE_BITS-1:0] site_z;
      logic                 in_box;
   } item_type;

   typedef struct packed {
      logic                 ok;
      logic [SIDE_BITS-1:0] idx;
   } axis_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      clamp_size = (s > SIZE_MAX) ? SIZE_MAX : s;
   endfunction

   // Moves one index by -1, 0 or +1 along an axis of the given size.
   function automatic axis_type axis_step(input logic [SIDE_BITS-1:0] idx,
                                          input logic [SIZE_W-1:0]    size,
                                          input logic                 per,
                                          input logic                 dec,
                                          input logic                 inc);
      axis_type r;
      r.ok  = 1'b1;
      r.idx = idx;
      if (dec) begin
         if (idx == '0) begin
            r.ok  = per;
            r.idx = SIDE_BITS'(size - SIZE_W'(1));
         end else begin
            r.idx = idx - SIDE_BITS'(1);
         end
      end else if (inc) begin
         if (({1'b0, idx} + SIZE_W'(1)) >= size) begin
            r.ok  = per;
            r.idx = '0;
         end else begin
            r.idx = idx + SIDE_BITS'(1);
         end
      end
      axis_step = r;
   endfunction

endpackage

// ===== src/cubic_lattice_neighbor_ids.sv =====
`timescale 1ns / 1ps
// Top level of the cubic lattice neighbor ID block: configuration registers
// and the front, queue and back parts. Depends on clni_pkg and the clni_front, clni_queue and clni_back modules.
//
// For each site transfer (site_x, site_y, site_z) this block produces six result
// transfers, one per unit offset in the order -x, -y, -z, +z, +y, +x, the sixth
// marked with last. A neighbor on a periodic axis wraps around the box; on a
// non-periodic axis a neighbor outside the box comes out with present low and
// all index and ID fields zero. A present neighbor carries its linear ID
// (z*size_y + y)*size_x + x, counted from 0. A site with any index at or beyond
// its axis size yields six absent results, and sizes above 1024 act as 1024.
// The back part issues one offset per cycle unless the result port stalls, so
// the block sustains one result per cycle under the same condition; the back
// part's direction counter sets the rate. A site accepted into an empty block
// shows its first result after the move from the front register into the
// queue and then the three back stages. The front register and a two-entry
// queue let new sites be accepted while the result port is stalled.
// Configuration writes take effect at once and must only be made while no
// site is in flight.
module cubic_lattice_neighbor_ids import clni_pkg::*; #(
   parameter int QUEUE_DEPTH = CLNI_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   // Raw register contents as written; sizes are clamped on the way out.
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic              periodic_x_ff, periodic_y_ff, periodic_z_ff;
   cfg_type           cfg;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop;
   item_type pop_item;

   // Writes to indexes beyond the register list fall through and are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff     <= SIZE_RESET;
         size_y_ff     <= SIZE_RESET;
         size_z_ff     <= SIZE_RESET;
         periodic_x_ff <= 1'b1;
         periodic_y_ff <= 1'b1;
         periodic_z_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X:     size_x_ff     <= csr_wdata;
            CSR_SIZE_Y:     size_y_ff     <= csr_wdata;
            CSR_SIZE_Z:     size_z_ff     <= csr_wdata;
            CSR_PERIODIC_X: periodic_x_ff <= csr_wdata[0];
            CSR_PERIODIC_Y: periodic_y_ff <= csr_wdata[0];
            CSR_PERIODIC_Z: periodic_z_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.size_x     = clamp_size(size_x_ff);
      cfg.size_y     = clamp_size(size_y_ff);
      cfg.size_z     = clamp_size(size_z_ff);
      cfg.periodic_x = periodic_x_ff;
      cfg.periodic_y = periodic_y_ff;
      cfg.periodic_z = periodic_z_ff;
   end

   clni_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   clni_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   clni_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/clni_front.sv =====
`timescale 1ns / 1ps
// Front part: takes a site transfer, checks it against the box and holds it
// in a register until the queue takes it. Depends on clni_pkg.
module clni_front import clni_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output item_type push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
      item_in.site_x = req_data.site_x;
      item_in.site_y = req_data.site_y;
      item_in.site_z = req_data.site_z;
      item_in.in_box = ({1'b0, req_data.site_x} < cfg.size_x)
                    && ({1'b0, req_data.site_y} < cfg.size_y)
                    && ({1'b0, req_data.site_z} < cfg.size_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== src/clni_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified sites between the front and back parts.
// Depends on clni_pkg.
module clni_queue import clni_pkg::*; #(
   parameter int DEPTH = CLNI_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/clni_back.sv =====
`timescale 1ns / 1ps
// Back part: walks the six offsets of the queue head, one per cycle when not stalled, and
// computes neighbor indices and linear IDs in a three-stage pipeline. Depends on clni_pkg.
module clni_back import clni_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     pop_valid,
   output logic     pop,
   input  item_type pop_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   typedef struct packed {
      logic                 present;
      logic [SIDE_BITS-1:0] nx;
      logic [SIDE_BITS-1:0] ny;
      logic [SIDE_BITS-1:0] nz;
      logic [DIR_W-1:0]     dir;
      logic                 last;
   } stage_type;

   localparam int PART_W = 2 * SIDE_BITS + 1;
   localparam int FULL_W = ID_W + 1;

   logic [DIR_W-1:0]  dir_ff, dir_in;
   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   stage_type         s1_ff, s1_in, s2_ff;
   logic [PART_W-1:0] part_ff, part_in;
   rsp_type           out_ff, out_in;
   logic              en1, en2, en3;
   axis_type          ax, ay, az;
   logic              ok;
   logic [FULL_W-1:0] full_prod;

   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign pop = pop_valid && en1 && (dir_ff == DIR_PLUS_X);

   assign rsp_valid = v3_ff;
   assign rsp_data  = out_ff;

   // Stage 1: neighbor indices for the current offset.
   always_comb begin
      ax = axis_step(pop_item.site_x, cfg.size_x, cfg.periodic_x,
                     dir_ff == DIR_MINUS_X, dir_ff == DIR_PLUS_X);
      ay = axis_step(pop_item.site_y, cfg.size_y, cfg.periodic_y,
                     dir_ff == DIR_MINUS_Y, dir_ff == DIR_PLUS_Y);
      az = axis_step(pop_item.site_z, cfg.size_z, cfg.periodic_z,
                     dir_ff == DIR_MINUS_Z, dir_ff == DIR_PLUS_Z);
      ok = pop_item.in_box && ax.ok && ay.ok && az.ok;

      s1_in.present = ok;
      s1_in.nx      = ok ? ax.idx : '0;
      s1_in.ny      = ok ? ay.idx : '0;
      s1_in.nz      = ok ? az.idx : '0;
      s1_in.dir     = dir_ff;
      s1_in.last    = (dir_ff == DIR_PLUS_X);

      dir_in = dir_ff;
      if (pop_valid && en1) begin
         dir_in = (dir_ff == DIR_PLUS_X) ? DIR_MINUS_X : dir_ff + DIR_W'(1);
      end
      v1_in = en1 ? pop_valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
   end

   // Stage 2: z * size_y + y.  Stage 3: that times size_x, plus x.
   always_comb begin
      part_in = PART_W'(s1_ff.nz) * PART_W'(cfg.size_y) + PART_W'(s1_ff.ny);
      full_prod = FULL_W'(part_ff) * FULL_W'(cfg.size_x);

      out_in.present     = s2_ff.present;
      out_in.neighbor_id = ID_W'(full_prod) + ID_W'(s2_ff.nx);
      out_in.neighbor_x  = s2_ff.nx;
      out_in.neighbor_y  = s2_ff.ny;
      out_in.neighbor_z  = s2_ff.nz;
      out_in.direction   = s2_ff.dir;
      out_in.last        = s2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_MINUS_X;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         dir_ff <= dir_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff   <= s1_ff;
         part_ff <= part_in;
      end
      if (en3) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== src/clni_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the cubic lattice neighbor ID block, bound to the top
// level. Depends on clni_pkg and cubic_lattice_neighbor_ids.
module clni_checker import clni_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Offset expected on the next result transfer.
   logic [DIR_W-1:0] exp_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_dir_ff <= DIR_MINUS_X;
      end else if (rsp_valid && rsp_ready) begin
         exp_dir_ff <= (exp_dir_ff == DIR_PLUS_X) ? DIR_MINUS_X
                                                  : exp_dir_ff + DIR_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_dir_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.direction == exp_dir_ff)
      else $error("result offsets out of order");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last == (rsp_data.direction == DIR_PLUS_X))
      else $error("last flag not on the +x result");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.present |-> rsp_data.neighbor_id == '0
         && rsp_data.neighbor_x == '0 && rsp_data.neighbor_y == '0
         && rsp_data.neighbor_z == '0)
      else $error("absent neighbor carries nonzero fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind cubic_lattice_neighbor_ids clni_checker u_clni_checker (.*);
